/* hw/rtl/csd_pkg.sv */
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types and constants of the circular scroll direction detector.
// ----------------------------------------------------------------------------
package csd_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned ThrW   = 16;
  localparam int unsigned StyleW = 2;
  localparam int unsigned KeyW   = 4;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned RunW   = 2;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ProdW  = 2 * DiffW;
  localparam int unsigned CrossW = ProdW + 1;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TURN_THRESHOLD = 1'd0,
    CFG_REPORT_STYLE   = 1'd1
  } cfg_idx_e;

  localparam logic [StyleW-1:0] STYLE_WHEEL = 2'd0;
  localparam logic [StyleW-1:0] STYLE_KEY   = 2'd1;

  localparam logic [KeyW-1:0] KEY_POSITIVE = 4'd4;
  localparam logic [KeyW-1:0] KEY_NEGATIVE = 4'd8;
  localparam logic [KeyW-1:0] KEY_NONE     = 4'd0;

  localparam logic signed [1:0] STEP_POSITIVE = 2'sd1;
  localparam logic signed [1:0] STEP_NEGATIVE = -2'sd1;
  localparam logic signed [1:0] STEP_NONE     = 2'sd0;

  localparam logic [RunW-1:0] RUN_MAX = 2'd3;
  localparam logic [ThrW-1:0] THR_RESET = 16'd15;

  typedef struct packed {
    logic fire;
    logic clear;
  } step_t;

  typedef struct packed {
    logic decide;
    logic positive;
    logic negative;
  } turn_t;

  typedef struct packed {
    logic              valid;
    logic              direction;
    logic signed [1:0] wheel_step;
    logic [KeyW-1:0]   key_code;
  } res_t;

endpackage

/* hw/rtl/csd_geom.sv */
// ----------------------------------------------------------------------------
// csd_geom
// Sample phase, point store and cross product. The two products are formed
// and registered when the third point arrives; the fourth sample subtracts
// them and compares against the threshold.
// ----------------------------------------------------------------------------
module csd_geom (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic [csd_pkg::CmdW-1:0]    cmd_i,
  input  logic [csd_pkg::CoordW-1:0]  pos_x_i,
  input  logic [csd_pkg::CoordW-1:0]  pos_y_i,
  input  logic [csd_pkg::ThrW-1:0]    thr_i,
  output csd_pkg::turn_t              turn_o
);
  import csd_pkg::*;

  logic [1:0]        phase_q, phase_d;
  logic [CoordW-1:0] x0_q, y0_q, x1_q, y1_q;
  logic signed [ProdW-1:0] prod_a_q, prod_b_q;

  logic signed [DiffW-1:0]  dx1, dy1, dx2, dy2;
  logic signed [ProdW-1:0]  prod_a, prod_b;
  logic signed [CrossW-1:0] cross_val, thr_s;
  logic sample;

  assign sample = fire_i && (cmd_i == CMD_SAMPLE);

  assign dx1 = $signed({1'b0, x1_q})    - $signed({1'b0, x0_q});
  assign dy1 = $signed({1'b0, y1_q})    - $signed({1'b0, y0_q});
  assign dx2 = $signed({1'b0, pos_x_i}) - $signed({1'b0, x0_q});
  assign dy2 = $signed({1'b0, pos_y_i}) - $signed({1'b0, y0_q});
  assign prod_a = ProdW'(dx1) * ProdW'(dy2);
  assign prod_b = ProdW'(dy1) * ProdW'(dx2);

  assign cross_val = CrossW'(prod_a_q) - CrossW'(prod_b_q);
  assign thr_s = $signed({{(CrossW-ThrW){1'b0}}, thr_i});

  assign turn_o.decide   = sample && (phase_q == 2'd3);
  assign turn_o.positive = cross_val > thr_s;
  assign turn_o.negative = cross_val < -thr_s;

  always_comb begin
    phase_d = phase_q;
    if (fire_i) begin
      case (cmd_i)
        CMD_RESTART: phase_d = 2'd0;
        CMD_SAMPLE:  phase_d = phase_q + 2'd1;
        default:     phase_d = phase_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample && phase_q == 2'd0) begin
      x0_q <= pos_x_i;
      y0_q <= pos_y_i;
    end
    if (sample && phase_q == 2'd1) begin
      x1_q <= pos_x_i;
      y1_q <= pos_y_i;
    end
    if (sample && phase_q == 2'd2) begin
      prod_a_q <= prod_a;
      prod_b_q <= prod_b;
    end
  end

endmodule

/* hw/rtl/csd_track.sv */
// ----------------------------------------------------------------------------
// csd_track
// Run counters and last-direction flag; suppresses isolated reversals and
// formats the result in the selected report style.
// ----------------------------------------------------------------------------
module csd_track (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  csd_pkg::step_t              step_i,
  input  csd_pkg::turn_t              turn_i,
  input  logic [csd_pkg::StyleW-1:0]  style_i,
  output csd_pkg::res_t               res_o
);
  import csd_pkg::*;

  logic [RunW-1:0] pos_run_q, pos_run_d, neg_run_q, neg_run_d;
  logic            last_q, last_d;
  logic            emit, neg;

  function automatic logic [RunW-1:0] run_inc(input logic [RunW-1:0] v);
    return (v == RUN_MAX) ? RUN_MAX : v + 1'b1;
  endfunction

  always_comb begin
    pos_run_d = pos_run_q;
    neg_run_d = neg_run_q;
    last_d    = last_q;
    emit      = 1'b0;
    neg       = 1'b0;
    if (step_i.fire && step_i.clear) begin
      pos_run_d = '0;
      neg_run_d = '0;
      last_d    = 1'b0;
    end else if (step_i.fire && turn_i.decide) begin
      if (turn_i.positive) begin
        pos_run_d = run_inc(pos_run_q);
        if (pos_run_q > 2'd1) begin
          last_d    = 1'b0;
          neg_run_d = '0;
          emit      = 1'b1;
        end else begin
          emit = !(last_q && neg_run_q > 2'd2);
        end
      end else if (turn_i.negative) begin
        neg       = 1'b1;
        neg_run_d = run_inc(neg_run_q);
        if (neg_run_q > 2'd1) begin
          last_d    = 1'b1;
          pos_run_d = '0;
          emit      = 1'b1;
        end else begin
          emit = !(!last_q && pos_run_q > 2'd2);
        end
      end
    end
  end

  always_comb begin
    res_o.valid      = emit && (style_i == STYLE_WHEEL || style_i == STYLE_KEY);
    res_o.direction  = neg;
    res_o.wheel_step = STEP_NONE;
    res_o.key_code   = KEY_NONE;
    if (style_i == STYLE_WHEEL) begin
      res_o.wheel_step = neg ? STEP_NEGATIVE : STEP_POSITIVE;
    end else begin
      res_o.key_code = neg ? KEY_NEGATIVE : KEY_POSITIVE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_run_q <= '0;
      neg_run_q <= '0;
      last_q    <= 1'b0;
    end else begin
      pos_run_q <= pos_run_d;
      neg_run_q <= neg_run_d;
      last_q    <= last_d;
    end
  end

endmodule

/* hw/rtl/circular_scroll_direction_detector_unit.sv */
// ----------------------------------------------------------------------------
// circular_scroll_direction_detector_unit
// Groups touch samples in fours and emits scroll steps from the sign of the
// cross product of the first three points.
// ----------------------------------------------------------------------------
// Pipeline: an input transfer passes the input register, then the result
//   register. Throughput: one item per cycle while out_stall_i is low;
//   the products are formed and registered on the third sample, so the
//   fourth only needs a subtract and compare.
// Reset: asynchronous, active low; clears phase, run history, handshake
//   state and loads the configuration defaults. The point store is not reset.
// ----------------------------------------------------------------------------
module circular_scroll_direction_detector_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [csd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [csd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [csd_pkg::CmdW-1:0]      command_i,
  input  logic [csd_pkg::CoordW-1:0]    pos_x_i,
  input  logic [csd_pkg::CoordW-1:0]    pos_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          direction_o,
  output logic signed [1:0]             wheel_step_o,
  output logic [csd_pkg::KeyW-1:0]      key_code_o
);
  import csd_pkg::*;

  logic [ThrW-1:0]   thr_q;
  logic [StyleW-1:0] style_q;

  logic              a_valid_q, a_valid_d;
  logic [CmdW-1:0]   a_cmd_q;
  logic [CoordW-1:0] a_x_q, a_y_q;

  logic   advance, fire, in_xfer;
  step_t  step;
  turn_t  turn;
  res_t   res;

  logic              out_valid_q, out_valid_d;
  logic              dir_q;
  logic signed [1:0] wheel_q;
  logic [KeyW-1:0]   key_q;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THR_RESET;
      style_q <= STYLE_WHEEL;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TURN_THRESHOLD: thr_q   <= cfg_data_i[ThrW-1:0];
        CFG_REPORT_STYLE:   style_q <= cfg_data_i[StyleW-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = a_valid_q && advance;
  assign in_stall_o = a_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_xfer) begin
      a_valid_d = 1'b1;
    end else if (advance) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_cmd_q <= command_i;
      a_x_q   <= pos_x_i;
      a_y_q   <= pos_y_i;
    end
  end

  assign step.fire  = fire;
  assign step.clear = (a_cmd_q == CMD_CLEAR);

  csd_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .cmd_i   (a_cmd_q),
    .pos_x_i (a_x_q),
    .pos_y_i (a_y_q),
    .thr_i   (thr_q),
    .turn_o  (turn)
  );

  csd_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .turn_i  (turn),
    .style_i (style_q),
    .res_o   (res)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = fire && res.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      dir_q   <= res.direction;
      wheel_q <= res.wheel_step;
      key_q   <= res.key_code;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign direction_o  = dir_q;
  assign wheel_step_o = wheel_q;
  assign key_code_o   = key_q;

endmodule

/* hw/rtl/csd_checker.sv */
// ----------------------------------------------------------------------------
// csd_checker
// Port-level checks of the scroll detector, bound to the top level.
// ----------------------------------------------------------------------------
module csd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          direction_o,
  input logic signed [1:0]             wheel_step_o,
  input logic [csd_pkg::KeyW-1:0]      key_code_o
);
  import csd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(direction_o)
      && $stable(wheel_step_o) && $stable(key_code_o))
    else $error("stalled result changed");

  // exactly one style field carries the result
  a_one_style: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (wheel_step_o == STEP_NONE) != (key_code_o == KEY_NONE))
    else $error("wheel step and key code both set or both clear");

  // fields agree with direction
  a_dir_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (wheel_step_o == STEP_NONE
        || wheel_step_o == (direction_o ? STEP_NEGATIVE : STEP_POSITIVE))
      && (key_code_o == KEY_NONE
        || key_code_o == (direction_o ? KEY_NEGATIVE : KEY_POSITIVE)))
    else $error("result fields disagree with direction");

  // a new result follows an input transfer through the input and result registers
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a preceding transfer");

endmodule

bind circular_scroll_direction_detector_unit csd_checker u_csd_checker (.*);

/* tb/circular_scroll_direction_detector_unit_tb.sv */
// ----------------------------------------------------------------------------
// circular_scroll_direction_detector_unit_tb
// Drives touch samples and commands into the scroll detector and tracks the
// turn history in a local predictor. Every result transfer is checked field
// by field against the oldest predicted scroll step. Covers threshold edges,
// full-range cross products, run history, all report styles and receiver
// back-pressure.
// ----------------------------------------------------------------------------
module circular_scroll_direction_detector_unit_tb;
  import csd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned ITEM_TARGET   = 1950;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned SETTLE_CYCLES = 8;

  localparam logic [CmdW-1:0]   CMD_IGNORED  = 2'd3;
  localparam logic [StyleW-1:0] STYLE_SILENT = 2'd2;
  localparam logic [StyleW-1:0] STYLE_SPARE  = 2'd3;

  typedef struct packed {
    logic              direction;
    logic signed [1:0] wheel_step;
    logic [KeyW-1:0]   key_code;
  } scroll_step_t;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CmdW-1:0]     command_i  = '0;
  logic [CoordW-1:0]   pos_x_i    = '0;
  logic [CoordW-1:0]   pos_y_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                direction_o;
  logic signed [1:0]   wheel_step_o;
  logic [KeyW-1:0]     key_code_o;

  circular_scroll_direction_detector_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .direction_o  (direction_o),
    .wheel_step_o (wheel_step_o),
    .key_code_o   (key_code_o)
  );

  always #5 clk_i = ~clk_i;

  scroll_step_t scroll_steps_due[$];
  int unsigned  errors      = 0;
  int unsigned  item_count  = 0;
  int unsigned  cycle_count = 0;
  bit           calm        = 1'b1;
  bit           hold_req    = 1'b0;
  int unsigned  hold_left   = 0;

  // predictor state
  logic [CoordW-1:0] pt_x[3];
  logic [CoordW-1:0] pt_y[3];
  logic [1:0]        phase     = '0;
  logic [RunW-1:0]   pos_run   = '0;
  logic [RunW-1:0]   neg_run   = '0;
  logic              last_neg  = 1'b0;
  logic [ThrW-1:0]   thr_cfg   = THR_RESET;
  logic [StyleW-1:0] style_cfg = STYLE_WHEEL;

  function automatic longint turn_area(input logic [CoordW-1:0] x0, y0, x1, y1, x2, y2);
    return (longint'(x1) - longint'(x0)) * (longint'(y2) - longint'(y0)) -
           (longint'(y1) - longint'(y0)) * (longint'(x2) - longint'(x0));
  endfunction

  function automatic void report_turn(input logic neg);
    scroll_step_t s;
    s.direction = neg;
    if (style_cfg == STYLE_WHEEL) begin
      s.wheel_step = neg ? STEP_NEGATIVE : STEP_POSITIVE;
      s.key_code   = KEY_NONE;
      scroll_steps_due.push_back(s);
    end else if (style_cfg == STYLE_KEY) begin
      s.wheel_step = STEP_NONE;
      s.key_code   = neg ? KEY_NEGATIVE : KEY_POSITIVE;
      scroll_steps_due.push_back(s);
    end
  endfunction

  function automatic void predict_scroll(input logic [CmdW-1:0] cmd,
                                         input logic [CoordW-1:0] x, y);
    longint          area;
    longint          thr;
    logic [RunW-1:0] old;
    case (cmd)
      CMD_RESTART: phase = '0;
      CMD_CLEAR: begin
        pos_run  = '0;
        neg_run  = '0;
        last_neg = 1'b0;
      end
      CMD_SAMPLE: begin
        if (phase < 2'd3) begin
          pt_x[phase] = x;
          pt_y[phase] = y;
          phase = phase + 2'd1;
        end else begin
          phase = '0;
          area = turn_area(pt_x[0], pt_y[0], pt_x[1], pt_y[1], pt_x[2], pt_y[2]);
          thr  = longint'(thr_cfg);
          if (area > thr) begin
            old = pos_run;
            pos_run = (old == RUN_MAX) ? RUN_MAX : old + 2'd1;
            if (old > 2'd1) begin
              last_neg = 1'b0;
              neg_run  = '0;
              report_turn(1'b0);
            end else if (!(last_neg && neg_run > 2'd2)) begin
              report_turn(1'b0);
            end
          end else if (area < -thr) begin
            old = neg_run;
            neg_run = (old == RUN_MAX) ? RUN_MAX : old + 2'd1;
            if (old > 2'd1) begin
              last_neg = 1'b1;
              pos_run  = '0;
              report_turn(1'b1);
            end else if (!(!last_neg && pos_run > 2'd2)) begin
              report_turn(1'b1);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin : check_results
    scroll_step_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (scroll_steps_due.size() == 0) begin
        $error("unexpected result: direction %0d wheel_step %0d key_code %0d",
               direction_o, wheel_step_o, key_code_o);
        errors++;
      end else begin
        want = scroll_steps_due.pop_front();
        if (direction_o !== want.direction) begin
          $error("direction: expected %0d, got %0d", want.direction, direction_o);
          errors++;
        end
        if (wheel_step_o !== want.wheel_step) begin
          $error("wheel_step: expected %0d, got %0d", want.wheel_step, wheel_step_o);
          errors++;
        end
        if (key_code_o !== want.key_code) begin
          $error("key_code: expected %0d, got %0d", want.key_code, key_code_o);
          errors++;
        end
      end
    end
  end

  // receiver stall, with long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 37);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("circular_scroll_direction_detector_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [CoordW-1:0] x, y);
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    pos_x_i    <= x;
    pos_y_i    <= y;
    do @(posedge clk_i); while (in_stall_o);
    predict_scroll(cmd, x, y);
    if (cmd != CMD_IGNORED) item_count++;
    if (!calm) begin
      while ($urandom_range(99) < 37) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  task automatic send_triangle(input logic [CoordW-1:0] x0, y0, x1, y1, x2, y2);
    send_item(CMD_SAMPLE, x0, y0);
    send_item(CMD_SAMPLE, x1, y1);
    send_item(CMD_SAMPLE, x2, y2);
    send_item(CMD_SAMPLE, 16'($urandom()), 16'($urandom()));
  endtask

  // mode 0: full range, 1: small spread, 2: area right at the threshold
  task automatic send_gesture(input int mode, input bit want_neg);
    logic [CoordW-1:0] px[3];
    logic [CoordW-1:0] py[3];
    logic [CoordW-1:0] t;
    longint            area;
    int                span, cx, cy, k;
    case (mode)
      0: begin
        for (int i = 0; i < 3; i++) begin
          px[i] = 16'($urandom());
          py[i] = 16'($urandom());
        end
      end
      1: begin
        span = int'($urandom_range(400, 1));
        cx = int'($urandom_range(65535 - span, span));
        cy = int'($urandom_range(65535 - span, span));
        for (int i = 0; i < 3; i++) begin
          px[i] = 16'(cx + int'($urandom_range(2 * span)) - span);
          py[i] = 16'(cy + int'($urandom_range(2 * span)) - span);
        end
      end
      default: begin
        k = int'(thr_cfg) + int'($urandom_range(3)) - 1;
        if (k < 0) k = 0;
        if (k > 65535) k = 65535;
        cx = int'($urandom_range(65534));
        cy = int'($urandom_range(65535 - k));
        px[0] = 16'(cx);     py[0] = 16'(cy);
        px[1] = 16'(cx + 1); py[1] = 16'(cy);
        px[2] = 16'(cx);     py[2] = 16'(cy + k);
      end
    endcase
    area = turn_area(px[0], py[0], px[1], py[1], px[2], py[2]);
    if (want_neg ? (area > 0) : (area < 0)) begin
      t = px[1]; px[1] = px[2]; px[2] = t;
      t = py[1]; py[1] = py[2]; py[2] = t;
    end
    send_triangle(px[0], py[0], px[1], py[1], px[2], py[2]);
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned target;
    int unsigned r, m;
    bit          lean;
    target = item_count + n;
    lean = 1'($urandom_range(1));
    while (item_count < target) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_item(CmdW'($urandom_range(3, 1)), 16'($urandom()), 16'($urandom()));
      end else if (r < 13) begin
        repeat ($urandom_range(2, 1)) send_item(CMD_SAMPLE, 16'($urandom()), 16'($urandom()));
        send_item(CMD_RESTART, 16'($urandom()), 16'($urandom()));
      end else begin
        if ($urandom_range(99) < 25) lean = ~lean;
        m = $urandom_range(9);
        send_gesture((m < 2) ? 0 : (m < 7) ? 1 : 2, lean);
      end
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (scroll_steps_due.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CFG_TURN_THRESHOLD) thr_cfg = data;
    else style_cfg = data[StyleW-1:0];
  endtask

  task automatic configure(input logic [ThrW-1:0] thr, input logic [StyleW-1:0] style);
    settle();
    write_reg(CFG_TURN_THRESHOLD, thr);
    write_reg(CFG_REPORT_STYLE, CfgDataW'(style));
    cfg_we_i <= 1'b0;
  endtask

  // reset defaults: threshold 15, wheel style
  task automatic check_directed_corners();
    send_triangle(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd15);
    send_triangle(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd16);
    send_item(CMD_SAMPLE, 16'hffff, 16'hffff);
    send_item(CMD_SAMPLE, 16'h0000, 16'h0000);
    send_item(CMD_RESTART, 16'hffff, 16'hffff);
    send_triangle(16'd0, 16'd0, 16'd0, 16'hffff, 16'hffff, 16'd0);
    send_item(CMD_CLEAR, 16'h0000, 16'hffff);
    send_item(CMD_IGNORED, 16'hffff, 16'h0000);
    send_triangle(16'hffff, 16'hffff, 16'hffff, 16'hfffe, 16'hfff0, 16'hffff);
    send_triangle(16'd0, 16'd0, 16'hffff, 16'd0, 16'd0, 16'hffff);
  endtask

  task automatic check_backpressure();
    settle();
    calm     = 1'b1;
    hold_req = 1'b1;
    repeat (15) send_gesture(0, 1'b0);
    calm = 1'b0;
  endtask

  task automatic check_register_sweep();
    configure(16'd0, STYLE_WHEEL);
    random_traffic(60);
    configure(16'd0, STYLE_KEY);
    random_traffic(60);
    configure(16'hffff, STYLE_SILENT);
    random_traffic(60);
    configure(16'hffff, STYLE_KEY);
    random_traffic(60);
    configure(16'($urandom()), STYLE_SPARE);
    random_traffic(60);
    configure(16'($urandom_range(1000)), STYLE_WHEEL);
    random_traffic(60);
    configure(16'd1, STYLE_KEY);
    random_traffic(60);
    configure(THR_RESET, STYLE_WHEEL);
    random_traffic(60);
  endtask

  task automatic check_random_gestures();
    bit first;
    first = 1'b1;
    while (item_count < ITEM_TARGET) begin
      configure(($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(500)),
                ($urandom_range(9) < 8) ? StyleW'($urandom_range(1)) : StyleW'($urandom_range(3)));
      calm = first;
      random_traffic(250);
      calm  = 1'b0;
      first = 1'b0;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    calm = 1'b0;
    check_directed_corners();
    check_backpressure();
    check_register_sweep();
    check_random_gestures();
    settle();
    if (errors == 0 && scroll_steps_due.size() == 0) begin
      $display("circular_scroll_direction_detector_unit_tb: done, clean");
    end else begin
      $display("circular_scroll_direction_detector_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/csd_pkg.sv
hw/rtl/csd_geom.sv
hw/rtl/csd_track.sv
hw/rtl/circular_scroll_direction_detector_unit.sv
hw/rtl/csd_checker.sv
tb/circular_scroll_direction_detector_unit_tb.sv
